@@ rtl/core/jmhp_pkg.sv @@
// Shared types and constants of the JPEG marker and frame-header parser.
package jmhp_pkg;

    localparam logic [7:0] MARK_PREFIX = 8'hFF;
    localparam logic [7:0] MARK_SOF0   = 8'hC0;
    localparam logic [7:0] MARK_SOI    = 8'hD8;
    localparam logic [7:0] MARK_EOI    = 8'hD9;
    localparam logic [7:0] MARK_TEM    = 8'h01;
    localparam logic [7:0] MARK_RST0   = 8'hD0;
    localparam logic [7:0] MARK_STUFF  = 8'h00;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [3:0] {
        PH_SOI_FF = 4'd0,
        PH_SOI_D8 = 4'd1,
        PH_SCAN   = 4'd2,
        PH_CODE   = 4'd3,
        PH_LEN_HI = 4'd4,
        PH_LEN_LO = 4'd5,
        PH_BODY   = 4'd6,
        PH_FAILED = 4'd7
    } phase_t;

    typedef enum logic [2:0] {
        FLD_PRECISION = 3'd0,
        FLD_HEIGHT_HI = 3'd1,
        FLD_HEIGHT_LO = 3'd2,
        FLD_WIDTH_HI  = 3'd3,
        FLD_WIDTH_LO  = 3'd4,
        FLD_COMPS     = 3'd5,
        FLD_DONE      = 3'd6,
        FLD_SPARE     = 3'd7
    } field_t;

    typedef struct packed {
        logic        marker_strobe;
        logic [7:0]  marker_code;
        logic        frame_valid;
        logic [7:0]  sample_precision;
        logic [15:0] picture_width;
        logic [15:0] picture_height;
        logic [7:0]  component_count;
        logic        not_jpeg;
        logic        done_res;
    } result_t;

endpackage

@@ rtl/core/jmhp_parser.sv @@
// Parser state registers and the next-state logic for one file byte.
module jmhp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              first_of_file,
    input  logic              last_of_file,
    output jmhp_pkg::result_t result
);
    import jmhp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [15:0] remain_reg, remain_next;
    field_t      field_reg, field_next;
    logic [7:0]  prec_reg, prec_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  comps_reg, comps_next;
    logic        seen_reg, seen_next;
    logic        error_reg, error_next;
    logic        strobe;
    logic [15:0] seg_len;

    always_comb
    begin
        // A restart clears everything before the byte is handled.
        if (first_of_file)
        begin
            phase_next  = PH_SOI_FF;
            marker_next = '0;
            remain_next = '0;
            field_next  = FLD_PRECISION;
            prec_next   = '0;
            width_next  = '0;
            height_next = '0;
            comps_next  = '0;
            seen_next   = 1'b0;
            error_next  = 1'b0;
        end
        else
        begin
            phase_next  = phase_reg;
            marker_next = marker_reg;
            remain_next = remain_reg;
            field_next  = field_reg;
            prec_next   = prec_reg;
            width_next  = width_reg;
            height_next = height_reg;
            comps_next  = comps_reg;
            seen_next   = seen_reg;
            error_next  = error_reg;
        end
        strobe  = 1'b0;
        seg_len = remain_next | {8'd0, data_byte};

        case (phase_next)
            PH_SOI_FF:
            begin
                if (data_byte == MARK_PREFIX)
                begin
                    phase_next = PH_SOI_D8;
                end
                else
                begin
                    error_next = 1'b1;
                    phase_next = PH_FAILED;
                end
            end
            PH_SOI_D8:
            begin
                if (data_byte == MARK_SOI)
                begin
                    marker_next = data_byte;
                    strobe      = 1'b1;
                    phase_next  = PH_SCAN;
                end
                else
                begin
                    error_next = 1'b1;
                    phase_next = PH_FAILED;
                end
            end
            PH_CODE:
            begin
                if (data_byte == MARK_PREFIX)
                begin
                    phase_next = PH_CODE;
                end
                else if (data_byte == MARK_STUFF)
                begin
                    phase_next = PH_SCAN;
                end
                else
                begin
                    marker_next = data_byte;
                    strobe      = 1'b1;
                    if (data_byte inside {MARK_TEM, [MARK_RST0:MARK_EOI]})
                    begin
                        phase_next = PH_SCAN;
                    end
                    else
                    begin
                        if (data_byte == MARK_SOF0)
                        begin
                            seen_next  = 1'b0;
                            field_next = FLD_PRECISION;
                        end
                        phase_next = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI:
            begin
                remain_next = {data_byte, 8'd0};
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                remain_next = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                phase_next  = (remain_next != 16'd0) ? PH_BODY : PH_SCAN;
            end
            PH_BODY:
            begin
                if (marker_next == MARK_SOF0)
                begin
                    case (field_next)
                        FLD_PRECISION:
                        begin
                            prec_next  = data_byte;
                            field_next = FLD_HEIGHT_HI;
                        end
                        FLD_HEIGHT_HI:
                        begin
                            height_next = {data_byte, height_next[7:0]};
                            field_next  = FLD_HEIGHT_LO;
                        end
                        FLD_HEIGHT_LO:
                        begin
                            height_next = {height_next[15:8], data_byte};
                            field_next  = FLD_WIDTH_HI;
                        end
                        FLD_WIDTH_HI:
                        begin
                            width_next = {data_byte, width_next[7:0]};
                            field_next = FLD_WIDTH_LO;
                        end
                        FLD_WIDTH_LO:
                        begin
                            width_next = {width_next[15:8], data_byte};
                            field_next = FLD_COMPS;
                        end
                        FLD_COMPS:
                        begin
                            comps_next = data_byte;
                            seen_next  = 1'b1;
                            field_next = FLD_DONE;
                        end
                        default:
                        begin
                            field_next = field_next;
                        end
                    endcase
                end
                if (remain_next != 16'd0)
                begin
                    remain_next = remain_next - 16'd1;
                end
                if (remain_next == 16'd0)
                begin
                    phase_next = PH_SCAN;
                end
            end
            PH_FAILED:
            begin
                phase_next = PH_FAILED;
            end
            default:
            begin
                if (data_byte == MARK_PREFIX)
                begin
                    phase_next = PH_CODE;
                end
            end
        endcase

        // A file that ends before the start marker is complete is not JPEG.
        if (last_of_file && (phase_next == PH_SOI_FF || phase_next == PH_SOI_D8))
        begin
            error_next = 1'b1;
            phase_next = PH_FAILED;
        end

        result.marker_strobe    = strobe;
        result.marker_code      = marker_next;
        result.frame_valid      = seen_next;
        result.sample_precision = prec_next;
        result.picture_width    = width_next;
        result.picture_height   = height_next;
        result.component_count  = comps_next;
        result.not_jpeg         = error_next;
        result.done_res         = last_of_file;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOI_FF;
            marker_reg <= '0;
            remain_reg <= '0;
            field_reg  <= FLD_PRECISION;
            prec_reg   <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            comps_reg  <= '0;
            seen_reg   <= 1'b0;
            error_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            marker_reg <= marker_next;
            remain_reg <= remain_next;
            field_reg  <= field_next;
            prec_reg   <= prec_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            comps_reg  <= comps_next;
            seen_reg   <= seen_next;
            error_reg  <= error_next;
        end
    end

    // The failed phase is left only through a restart.
    a_failed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FAILED && !(step_en && first_of_file)
        |=> phase_reg == PH_FAILED)
        else $error("parser left the failed phase without a restart");

    // The error flag is only ever set together with the failed phase.
    a_error_failed: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> phase_reg == PH_FAILED)
        else $error("format error raised outside the failed phase");

    // A complete frame header means all six fields were taken.
    a_seen_fields: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> field_reg == FLD_DONE)
        else $error("frame marked valid before all fields were captured");

endmodule

@@ rtl/core/jpeg_marker_header_parser.sv @@
// Top level of the JPEG marker and frame-header parser with its stream ports.
//
// The parser takes one file byte per beat and gives exactly one result beat for
// every byte, in order. It accepts a byte in every clock cycle while the output
// side keeps up; an accepted byte is held first in the input register and then
// passes through the parsing logic into the result register as soon as the
// output has room, and the only loop is the parser state, which is updated
// in the cycle that moves a byte from the input register to the result
// register. The first byte of a file must carry tuser high, which clears all
// parser state; tlast on the input marks the final byte and comes
// back as tlast on the matching result. The file must open with
// 0xFF 0xD8, or not_jpeg is raised and the rest of the file is ignored. Each
// marker code is reported with a strobe, segment bodies are skipped by their
// big-endian length, and the precision, height, width and component count of a
// baseline SOF0 header are captured; frame_valid goes high once all six header
// bytes are in.
module jpeg_marker_header_parser (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [jmhp_pkg::IN_TDATA_W-1:0]       s_tdata,  // [7:0] data_byte
    input  logic                                  s_tuser,  // [0] first_of_file
    input  logic                                  s_tlast,  // last_of_file
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata, lowest bit up: [7:0] marker_code, [8] frame_valid,
    // [16:9] sample_precision, [32:17] picture_width, [48:33] picture_height,
    // [56:49] component_count, [57] not_jpeg, [63:58] zero
    output logic [jmhp_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                  m_tuser,  // [0] marker_strobe
    output logic                                  m_tlast   // done_res
);
    import jmhp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_result;
    logic       out_free;
    logic       step_en;

    // The result register can take a new beat when it is empty or being read.
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg  <= s_tdata[7:0];
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
        if (step_en)
        begin
            out_reg <= step_result;
        end
    end

    jmhp_parser u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .data_byte     (in_byte_reg),
        .first_of_file (in_first_reg),
        .last_of_file  (in_last_reg),
        .result        (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.marker_strobe;
    assign m_tlast  = out_reg.done_res;
    assign m_tdata  = {6'd0,
                       out_reg.not_jpeg,
                       out_reg.component_count,
                       out_reg.picture_height,
                       out_reg.picture_width,
                       out_reg.sample_precision,
                       out_reg.frame_valid,
                       out_reg.marker_code};

    // A byte waiting in the input register moves on whenever the output has room.
    a_byte_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_free |=> out_valid_reg)
        else $error("pending byte did not reach the result register");

endmodule

@@ tb/jpeg_marker_header_parser_tb.sv @@
// Self-checking testbench for the JPEG marker and frame-header parser.
module jpeg_marker_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jmhp_pkg::*;

    // APP0 is used as an ordinary segment-bearing marker in the stimulus.
    localparam logic [7:0] MARK_APP0 = 8'hE0;

    typedef logic [7:0] byte_q_t[$];

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] data_byte
    logic                   s_tuser  = 1'b0; // [0] first_of_file
    logic                   s_tlast  = 1'b0; // last_of_file
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata, lowest bit up: [7:0] marker_code, [8] frame_valid,
    // [16:9] sample_precision, [32:17] picture_width, [48:33] picture_height,
    // [56:49] component_count, [57] not_jpeg, [63:58] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;         // [0] marker_strobe
    logic                   m_tlast;         // done_res

    jpeg_marker_header_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // The parser state as the testbench believes it to be.
    phase_t      ph;
    logic [7:0]  cur_marker;
    logic [15:0] seg_left;
    logic [2:0]  fld_idx;
    logic [7:0]  prec;
    logic [15:0] wid;
    logic [15:0] hgt;
    logic [7:0]  comps;
    logic        frm_seen;
    logic        bad_start;

    result_t expected_results[$];

    // When set, both the byte source and the result sink pause at random.
    bit idle_on = 1'b0;

    int error_count      = 0;
    int bytes_sent       = 0;
    int files_sent       = 0;
    int results_checked  = 0;
    int strobes_seen     = 0;
    int headers_captured = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous ceiling: well above the slowest correct run with every byte
    // waiting out the longest source gap and the longest sink stall.
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic bit is_standalone_code(input logic [7:0] code);
        return code == MARK_TEM || (code >= MARK_RST0 && code <= MARK_EOI);
    endfunction

    function automatic void clear_parser();
        ph         = PH_SOI_FF;
        cur_marker = '0;
        seg_left   = '0;
        fld_idx    = '0;
        prec       = '0;
        wid        = '0;
        hgt        = '0;
        comps      = '0;
        frm_seen   = 1'b0;
        bad_start  = 1'b0;
    endfunction

    // Advances the predicted parser state by one file byte and returns the
    // result beat that byte should produce.
    function automatic result_t parse_byte(input logic [7:0] b, input logic first,
                                           input logic last);
        result_t     r;
        logic [15:0] seg_len;
        logic        strobe;
        strobe = 1'b0;
        if (first)
            clear_parser();
        case (ph)
            PH_SOI_FF:
            begin
                if (b == MARK_PREFIX)
                    ph = PH_SOI_D8;
                else
                begin
                    bad_start = 1'b1;
                    ph        = PH_FAILED;
                end
            end
            PH_SOI_D8:
            begin
                if (b == MARK_SOI)
                begin
                    cur_marker = b;
                    strobe     = 1'b1;
                    ph         = PH_SCAN;
                end
                else
                begin
                    bad_start = 1'b1;
                    ph        = PH_FAILED;
                end
            end
            PH_CODE:
            begin
                // A fill byte keeps us waiting for the code; a stuffed zero
                // is no marker at all.
                if (b == MARK_STUFF)
                    ph = PH_SCAN;
                else if (b != MARK_PREFIX)
                begin
                    cur_marker = b;
                    strobe     = 1'b1;
                    if (is_standalone_code(b))
                        ph = PH_SCAN;
                    else
                    begin
                        if (b == MARK_SOF0)
                        begin
                            frm_seen = 1'b0;
                            fld_idx  = FLD_PRECISION;
                        end
                        ph = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI:
            begin
                seg_left = {b, 8'h00};
                ph       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                seg_len  = seg_left | {8'h00, b};
                seg_left = (seg_len >= 16'd2) ? seg_len - 16'd2 : 16'd0;
                ph       = (seg_left != 16'd0) ? PH_BODY : PH_SCAN;
            end
            PH_BODY:
            begin
                if (cur_marker == MARK_SOF0 && fld_idx <= FLD_COMPS)
                begin
                    case (fld_idx)
                        FLD_PRECISION: prec       = b;
                        FLD_HEIGHT_HI: hgt[15:8]  = b;
                        FLD_HEIGHT_LO: hgt[7:0]   = b;
                        FLD_WIDTH_HI:  wid[15:8]  = b;
                        FLD_WIDTH_LO:  wid[7:0]   = b;
                        default:
                        begin
                            comps    = b;
                            frm_seen = 1'b1;
                            headers_captured++;
                        end
                    endcase
                    fld_idx = fld_idx + 3'd1;
                end
                if (seg_left != 16'd0)
                    seg_left = seg_left - 16'd1;
                if (seg_left == 16'd0)
                    ph = PH_SCAN;
            end
            PH_FAILED: ;
            default:
            begin
                if (b == MARK_PREFIX)
                    ph = PH_CODE;
            end
        endcase
        // A file that ends before its start marker is complete is not JPEG.
        if (last && (ph == PH_SOI_FF || ph == PH_SOI_D8))
        begin
            bad_start = 1'b1;
            ph        = PH_FAILED;
        end
        r.marker_strobe    = strobe;
        r.marker_code      = cur_marker;
        r.frame_valid      = frm_seen;
        r.sample_precision = prec;
        r.picture_width    = wid;
        r.picture_height   = hgt;
        r.component_count  = comps;
        r.not_jpeg         = bad_start;
        r.done_res         = last;
        return r;
    endfunction

    // Mostly short pauses, now and then a long one, none while idling is off.
    function automatic int idle_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Presents one byte, waits for the handshake and records the result it
    // should produce. Always called, and always returns, at a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        int gap;
        gap = idle_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(parse_byte(b, first, last));
        bytes_sent++;
    endtask

    task automatic send_file(input byte_q_t file_bytes, input bit restart,
                             input bit mark_last);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], restart && i == 0,
                      mark_last && i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // Result sink: random back-pressure while idling is on, otherwise always
    // ready.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = idle_gap();
            if (n == 0)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at result %0d: %s", results_checked, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
            report_error($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    // Every result beat is compared field by field with the oldest
    // outstanding prediction.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_error("result beat with no byte outstanding");
            else
            begin
                want = expected_results.pop_front();
                check_field("marker_strobe", want.marker_strobe, m_tuser);
                check_field("marker_code", want.marker_code, m_tdata[7:0]);
                check_field("frame_valid", want.frame_valid, m_tdata[8]);
                check_field("sample_precision", want.sample_precision, m_tdata[16:9]);
                check_field("picture_width", want.picture_width, m_tdata[32:17]);
                check_field("picture_height", want.picture_height, m_tdata[48:33]);
                check_field("component_count", want.component_count, m_tdata[56:49]);
                check_field("not_jpeg", want.not_jpeg, m_tdata[57]);
                check_field("done_res", want.done_res, m_tlast);
                check_field("tdata padding", 16'd0, m_tdata[63:58]);
            end
            results_checked++;
            if (m_tuser === 1'b1)
                strobes_seen++;
        end
    end

    // Broken and truncated openings, bytes ignored after a bad start, and a
    // restart in the middle of a segment.
    task automatic test_start_of_image();
        send_file('{8'h00}, 1'b1, 1'b1);
        send_file('{MARK_PREFIX, MARK_STUFF, MARK_PREFIX, MARK_SOF0}, 1'b1, 1'b0);
        send_file('{MARK_PREFIX}, 1'b1, 1'b1);
        send_file('{MARK_PREFIX, MARK_SOI, MARK_PREFIX, MARK_APP0, 8'h00}, 1'b1, 1'b0);
    endtask

    // One hand-built file covering stuffed zeros, fill bytes, standalone
    // markers, a full SOF0 header at its extremes, a length below two, a short
    // SOF0 that replaces the first, and bytes after the last without restart.
    task automatic test_marker_segments();
        send_file('{MARK_PREFIX, MARK_SOI, 8'h5A,
                    MARK_PREFIX, MARK_STUFF,
                    MARK_PREFIX, MARK_PREFIX, MARK_TEM,
                    MARK_PREFIX, MARK_RST0 + 8'd7,
                    MARK_PREFIX, MARK_SOF0, 8'h00, 8'h08,
                    8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h03,
                    MARK_PREFIX, MARK_APP0, 8'h00, 8'h01,
                    MARK_PREFIX, MARK_SOF0, 8'h00, 8'h04, 8'h08, 8'h00,
                    MARK_PREFIX, MARK_EOI}, 1'b1, 1'b1);
        send_file('{MARK_PREFIX, MARK_SOI}, 1'b0, 1'b1);
    endtask

    // Builds one random file: mostly well-formed marker streams with random
    // content, some with a broken start, some plain noise.
    task automatic random_file();
        byte_q_t     contents;
        int          kind;
        int          r;
        int          body_n;
        logic [15:0] len;
        logic [7:0]  code;
        bit          cut;
        bit          restart;
        bit          mark_last;
        kind      = $urandom_range(0, 99);
        cut       = 1'b0;
        restart   = 1'b1;
        mark_last = ($urandom_range(0, 19) != 0);
        if (kind < 8)
        begin
            repeat ($urandom_range(1, 4))
                contents.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                               : MARK_PREFIX);
            // Occasionally the real start code is put in the second byte.
            if (contents.size() > 1 && $urandom_range(0, 1) == 0)
                contents[1] = MARK_SOI;
        end
        else if (kind < 14)
        begin
            repeat ($urandom_range(1, 20))
                contents.push_back(($urandom_range(0, 3) == 0) ? MARK_PREFIX
                                                               : 8'($urandom_range(0, 255)));
        end
        else
        begin
            restart  = ($urandom_range(0, 19) != 0);
            contents = '{MARK_PREFIX, MARK_SOI};
            repeat ($urandom_range(1, 6))
            begin
                if (!cut)
                begin
                    // Scan data between segments, including stuffed zeros and
                    // fill bytes before the next marker.
                    repeat ($urandom_range(0, 2))
                    begin
                        r = $urandom_range(0, 2);
                        if (r == 0)
                            contents.push_back(8'($urandom_range(0, 254)));
                        else
                        begin
                            contents.push_back(MARK_PREFIX);
                            contents.push_back((r == 1) ? MARK_STUFF : MARK_PREFIX);
                        end
                    end
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        code = MARK_SOF0;
                    else if (r < 6)
                        code = ($urandom_range(0, 10) == 10) ? MARK_TEM
                                                             : MARK_RST0 + 8'($urandom_range(0, 9));
                    else
                        code = 8'($urandom_range(1, 254));
                    contents.push_back(MARK_PREFIX);
                    contents.push_back(code);
                    if (!is_standalone_code(code))
                    begin
                        r = $urandom_range(0, 19);
                        body_n = -1;
                        if (r == 0)
                            len = 16'($urandom_range(0, 1));
                        else if (r == 1)
                        begin
                            // A long segment; the file stops part-way through it.
                            len    = 16'($urandom_range(256, 65535));
                            body_n = $urandom_range(0, 6);
                            cut    = 1'b1;
                        end
                        else if (code == MARK_SOF0)
                            len = (r < 14) ? 16'd8 : 16'($urandom_range(3, 14));
                        else
                            len = 16'($urandom_range(2, 12));
                        if (body_n < 0)
                            body_n = (len >= 16'd2) ? int'(len) - 2 : 0;
                        contents.push_back(len[15:8]);
                        contents.push_back(len[7:0]);
                        repeat (body_n)
                            contents.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            if (!cut && $urandom_range(0, 3) != 0)
            begin
                contents.push_back(MARK_PREFIX);
                contents.push_back(MARK_EOI);
            end
        end
        send_file(contents, restart, mark_last);
    endtask

    task automatic test_random_files(input int n_bytes, input bit with_idling);
        int target;
        idle_on = with_idling;
        target  = bytes_sent + n_bytes;
        while (bytes_sent < target)
            random_file();
    endtask

    initial
    begin
        clear_parser();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        test_start_of_image();
        test_marker_segments();
        test_random_files(300, 1'b0);
        test_random_files(1000, 1'b1);
        s_tvalid <= 1'b0;

        // Drain, then keep watching for any stray beat to show.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d bytes in %0d files sent, %0d result beats checked",
                 bytes_sent, files_sent, results_checked);
        $display("%0d marker strobes seen, %0d complete SOF0 headers captured",
                 strobes_seen, headers_captured);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/jmhp_pkg.sv
rtl/core/jmhp_parser.sv
rtl/core/jpeg_marker_header_parser.sv
tb/jpeg_marker_header_parser_tb.sv
